// ===== sv/mjpeg_http_part_deframer_unit_macros.svh =====
// assertion macros shared by the deframer rtl
`ifndef MJPEG_HTTP_PART_DEFRAMER_UNIT_MACROS_SVH
`define MJPEG_HTTP_PART_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MHPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mhpd implication check failed");

// next-cycle implication, disabled while reset is low
`define MHPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mhpd next-cycle check failed");

`endif

// ===== sv/mhpd_pkg.sv =====
// shared result kinds and the result struct of the deframer
`default_nettype none

package mhpd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_NO_LEN   = 2'd2;
    localparam logic [1:0] KIND_NEG_LEN  = 2'd3;

    // one result word from the parser core
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/mhpd_core.sv =====
// header parser and payload counter: state registers and next-state logic
`default_nettype none

module mhpd_core #(
    parameter int LENGTH_WIDTH = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [7:0]       i_byte,
    output mhpd_pkg::t_result     o_result
);

    localparam int LW = LENGTH_WIDTH;
    localparam int WW = LENGTH_WIDTH + 4;

    // phase codes
    localparam logic [2:0] PH_KEY      = 3'd0;
    localparam logic [2:0] PH_VALUE    = 3'd1;
    localparam logic [2:0] PH_SKIPLINE = 3'd2;
    localparam logic [2:0] PH_PAYLOAD  = 3'd3;
    localparam logic [2:0] PH_STOPPED  = 3'd4;

    // value parser codes
    localparam logic [2:0] VS_SKIP   = 3'd0;
    localparam logic [2:0] VS_SPACE  = 3'd1;
    localparam logic [2:0] VS_SIGN   = 3'd2;
    localparam logic [2:0] VS_DIGITS = 3'd3;
    localparam logic [2:0] VS_DONE   = 3'd4;

    localparam logic [3:0] KEY_LEN = 4'd14;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // header key text, one character per position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [2:0]    r_phase,    n_phase;
    logic [3:0]    r_key_pos,  n_key_pos;
    logic          r_key_ok,   n_key_ok;
    logic          r_len_found, n_len_found;
    logic [2:0]    r_vsub,     n_vsub;
    logic          r_neg,      n_neg;
    logic [LW-1:0] r_acc,      n_acc;
    logic [1:0]    r_term,     n_term;
    logic [LW-1:0] r_remain,   n_remain;

    logic          w_is_digit;
    logic          w_is_space;
    logic [WW-1:0] w_acc_wide;
    logic [LW-1:0] w_acc_sat;
    logic [LW-1:0] w_remain_dec;
    logic          w_do_digit;
    logic          w_done;
    logic          w_restart;
    mhpd_pkg::t_result w_res;

    // character classes
    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_is_space = (i_byte == CH_SPACE) || (i_byte == CH_TAB) || (i_byte == CH_VT)
                     || (i_byte == CH_FF) || (i_byte == CH_CR);

    // acc * 10 + digit with saturation at all ones
    assign w_acc_wide = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                      + {{(WW-4){1'b0}}, i_byte[3:0]};
    assign w_acc_sat  = (|w_acc_wide[WW-1:LW]) ? {LW{1'b1}} : w_acc_wide[LW-1:0];

    assign w_remain_dec = r_remain - {{(LW-1){1'b0}}, 1'b1};

    // next-state and result logic for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_key_pos   = r_key_pos;
        n_key_ok    = r_key_ok;
        n_len_found = r_len_found;
        n_vsub      = r_vsub;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_term      = r_term;
        n_remain    = r_remain;
        w_do_digit  = 1'b0;
        w_done      = 1'b0;
        w_restart   = 1'b0;
        w_res       = '0;

        unique case (r_phase)
            PH_STOPPED: begin
            end
            PH_PAYLOAD: begin
                n_remain   = w_remain_dec;
                w_res.valid = 1'b1;
                w_res.kind  = mhpd_pkg::KIND_PAYLOAD;
                w_res.data  = i_byte;
                w_res.last  = (w_remain_dec == '0);
                w_restart   = (w_remain_dec == '0);
            end
            default: begin
                // line parsing
                if (i_byte == CH_LF) begin
                    n_phase   = PH_KEY;
                    n_key_pos = 4'd0;
                    n_key_ok  = 1'b1;
                end else if (r_phase == PH_KEY) begin
                    if (i_byte == CH_COLON) begin
                        if (r_key_ok && (r_key_pos == KEY_LEN) && !r_len_found) begin
                            n_phase     = PH_VALUE;
                            n_len_found = 1'b1;
                            n_vsub      = VS_SKIP;
                            n_neg       = 1'b0;
                            n_acc       = '0;
                        end else begin
                            n_phase = PH_SKIPLINE;
                        end
                    end else if (r_key_ok && (r_key_pos < KEY_LEN)
                                 && (i_byte == key_char(r_key_pos))) begin
                        n_key_pos = r_key_pos + 4'd1;
                    end else begin
                        n_key_ok = 1'b0;
                    end
                end else if (r_phase == PH_VALUE) begin
                    unique case (r_vsub)
                        VS_SKIP: n_vsub = VS_SPACE;
                        VS_SPACE: begin
                            if (w_is_space) begin
                                n_vsub = r_vsub;
                            end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                                n_neg  = (i_byte == CH_MINUS);
                                n_vsub = VS_SIGN;
                            end else begin
                                w_do_digit = 1'b1;
                            end
                        end
                        VS_SIGN, VS_DIGITS: w_do_digit = 1'b1;
                        default: n_vsub = r_vsub;
                    endcase
                    if (w_do_digit) begin
                        if (w_is_digit) begin
                            n_acc  = w_acc_sat;
                            n_vsub = VS_DIGITS;
                        end else begin
                            n_vsub = VS_DONE;
                        end
                    end
                end

                // cr lf cr lf tracking
                if (i_byte == CH_CR) begin
                    n_term = (r_term == 2'd2) ? 2'd3 : 2'd1;
                end else if (i_byte == CH_LF) begin
                    w_done = (r_term == 2'd3);
                    n_term = (r_term == 2'd1) ? 2'd2 : 2'd0;
                end else begin
                    n_term = 2'd0;
                end

                // header end decision
                if (w_done) begin
                    w_res.valid = 1'b1;
                    if (!r_len_found) begin
                        n_phase    = PH_STOPPED;
                        w_res.kind = mhpd_pkg::KIND_NO_LEN;
                    end else if (r_acc == '0) begin
                        w_restart  = 1'b1;
                        w_res.kind = mhpd_pkg::KIND_EMPTY;
                        w_res.last = 1'b1;
                    end else if (r_neg) begin
                        n_phase    = PH_STOPPED;
                        w_res.kind = mhpd_pkg::KIND_NEG_LEN;
                    end else begin
                        w_res.valid = 1'b0;
                        n_remain    = r_acc;
                        n_phase     = PH_PAYLOAD;
                    end
                end
            end
        endcase

        // fresh header state
        if (w_restart) begin
            n_phase     = PH_KEY;
            n_key_pos   = 4'd0;
            n_key_ok    = 1'b1;
            n_len_found = 1'b0;
            n_vsub      = VS_SKIP;
            n_neg       = 1'b0;
            n_acc       = '0;
            n_term      = 2'd0;
        end
    end

    assign o_result = w_res;

    // state registers, advanced once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_KEY;
            r_key_pos   <= 4'd0;
            r_key_ok    <= 1'b1;
            r_len_found <= 1'b0;
            r_vsub      <= VS_SKIP;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_term      <= 2'd0;
            r_remain    <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_key_pos   <= n_key_pos;
            r_key_ok    <= n_key_ok;
            r_len_found <= n_len_found;
            r_vsub      <= n_vsub;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_term      <= n_term;
            r_remain    <= n_remain;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mjpeg_http_part_deframer_unit.sv =====
// top level of the multipart deframer: input register, parser core, output register
//
//   channel   dir   handshake                     contents
//   s_axis    in    s_axis_tvalid/s_axis_tready   tdata[7:0] in_byte
//   m_axis    out   m_axis_tvalid/m_axis_tready   tdata data_byte, tuser kind, tlast
//
// one byte per cycle sustained unless a full output register stalls a result; a byte is held
// in the input register until consumed, and its result (if any) then goes to the output register.
// the per-byte state update (key match, times-ten accumulate, length count)
// is combinational logic between those two registers.
// synchronous active-low reset returns to the start of a header, no clearing pass.
// a full output register stalls only bytes that produce a result.
`default_nettype none

module mjpeg_http_part_deframer_unit #(
    parameter int LENGTH_WIDTH = 31
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]      m_axis_tuser,   // [1:0] kind
    output logic            m_axis_tlast
);

    `include "mjpeg_http_part_deframer_unit_macros.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic              w_out_free;
    logic              w_fire;
    mhpd_pkg::t_result w_res;

    // parser core
    mhpd_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_fire),
        .i_byte    (r_in_byte),
        .o_result  (w_res)
    );

    // consume the held byte when it has no result or its result has a place to go
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && (w_out_free || !w_res.valid);
    assign s_axis_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.valid) begin
            r_out_kind <= w_res.kind;
            r_out_data <= w_res.data;
            r_out_last <= w_res.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // checks
    `MHPD_ASSERT_IMPLY(a_data_zero, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != mhpd_pkg::KIND_PAYLOAD), m_axis_tdata == 8'h00)
    `MHPD_ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == mhpd_pkg::KIND_EMPTY), m_axis_tlast)
    `MHPD_ASSERT_NEXT(a_stop_silent, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready
            && ((m_axis_tuser == mhpd_pkg::KIND_NO_LEN)
                || (m_axis_tuser == mhpd_pkg::KIND_NEG_LEN)),
        !m_axis_tvalid)
    `MHPD_ASSERT_IMPLY(a_drain_ready, i_clk, i_rst_n,
        r_in_valid && !r_out_valid, s_axis_tready)

endmodule

`default_nettype wire

// ===== tb/mjpeg_http_part_deframer_checker.sv =====
// checker for the multipart deframer: predicts each result word from the accepted bytes and compares
module mjpeg_http_part_deframer_checker #(
    parameter int LENGTH_WIDTH = 31
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    input  wire logic       i_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    input  wire logic [7:0] i_m_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0] i_m_axis_tuser,   // [1:0] kind
    input  wire logic       i_m_axis_tlast,
    output int              o_fail_count,
    output int              o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        KEY_CHARS = 14;
    localparam logic [8*KEY_CHARS-1:0]    KEY_TEXT  = "Content-Length";
    localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX   = '1;
    localparam logic [7:0]                CH_LF     = 8'h0A;
    localparam logic [7:0]                CH_CR     = 8'h0D;
    localparam logic [7:0]                CH_TAB    = 8'h09;
    localparam logic [7:0]                CH_VT     = 8'h0B;
    localparam logic [7:0]                CH_FF     = 8'h0C;
    localparam logic [7:0]                CH_SPACE  = 8'h20;
    localparam logic [7:0]                CH_PLUS   = 8'h2B;
    localparam logic [7:0]                CH_MINUS  = 8'h2D;
    localparam logic [7:0]                CH_ZERO   = 8'h30;
    localparam logic [7:0]                CH_NINE   = 8'h39;
    localparam logic [7:0]                CH_COLON  = 8'h3A;
    localparam int                        REPORT_MAX = 10;

    typedef enum logic [2:0] {
        HDR_KEY,
        HDR_VALUE,
        HDR_SKIP_LINE,
        IN_PAYLOAD,
        HALTED
    } t_parse_phase;

    typedef enum logic [2:0] {
        VAL_SKIP,
        VAL_SPACE,
        VAL_SIGN,
        VAL_DIGITS,
        VAL_DONE
    } t_value_step;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    // parser state
    t_parse_phase            phase;
    t_value_step             val_step;
    logic [3:0]              key_pos;
    logic                    key_ok;
    logic                    have_length;
    logic                    val_neg;
    logic [LENGTH_WIDTH-1:0] len_acc;
    logic [LENGTH_WIDTH-1:0] bytes_left;
    logic [1:0]              crlf_seen;

    // words still owed by the block, oldest first
    t_frame_word             owed_words[$];

    // back to the start of a header
    task automatic header_restart();
        phase       = HDR_KEY;
        key_pos     = '0;
        key_ok      = 1'b1;
        have_length = 1'b0;
        val_step    = VAL_SKIP;
        val_neg     = 1'b0;
        len_acc     = '0;
        crlf_seen   = 2'd0;
    endtask

    // one header or payload byte through the parser
    task automatic parse_byte(input logic [7:0] b, output logic produced,
                              output t_frame_word w);
        logic [LENGTH_WIDTH+3:0] sum;
        logic                    is_digit;
        logic                    is_blank;
        logic                    take_digit;
        logic                    header_done;
        is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
        is_blank    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
                      (b == CH_FF) || (b == CH_CR);
        take_digit  = 1'b0;
        header_done = 1'b0;
        produced    = 1'b0;
        w           = '0;
        case (phase)
            HALTED: begin
                produced = 1'b0;
            end
            IN_PAYLOAD: begin
                bytes_left = bytes_left - 1'b1;
                produced   = 1'b1;
                w.kind     = mhpd_pkg::KIND_PAYLOAD;
                w.data     = b;
                w.last     = (bytes_left == '0);
                if (bytes_left == '0) header_restart();
            end
            default: begin
                // line parsing
                if (b == CH_LF) begin
                    phase   = HDR_KEY;
                    key_pos = '0;
                    key_ok  = 1'b1;
                end else if (phase == HDR_KEY) begin
                    if (b == CH_COLON) begin
                        if (key_ok && key_pos == KEY_CHARS && !have_length) begin
                            phase       = HDR_VALUE;
                            have_length = 1'b1;
                            val_step    = VAL_SKIP;
                            val_neg     = 1'b0;
                            len_acc     = '0;
                        end else begin
                            phase = HDR_SKIP_LINE;
                        end
                    end else if (key_ok && key_pos < KEY_CHARS &&
                                 b == KEY_TEXT[8*(KEY_CHARS-1-key_pos) +: 8]) begin
                        key_pos = key_pos + 1'b1;
                    end else begin
                        key_ok = 1'b0;
                    end
                end else if (phase == HDR_VALUE) begin
                    // atoi-style value: skip one byte, blanks, sign, digits
                    case (val_step)
                        VAL_SKIP: begin
                            val_step = VAL_SPACE;
                        end
                        VAL_SPACE: begin
                            if (b == CH_PLUS || b == CH_MINUS) begin
                                val_neg  = (b == CH_MINUS);
                                val_step = VAL_SIGN;
                            end else if (!is_blank) begin
                                take_digit = 1'b1;
                            end
                        end
                        VAL_SIGN, VAL_DIGITS: begin
                            take_digit = 1'b1;
                        end
                        default: begin
                            take_digit = 1'b0;
                        end
                    endcase
                    if (take_digit) begin
                        if (is_digit) begin
                            sum      = {4'b0, len_acc} * 10 + b[3:0];
                            len_acc  = (sum > {4'b0, LEN_MAX}) ? LEN_MAX
                                                               : sum[LENGTH_WIDTH-1:0];
                            val_step = VAL_DIGITS;
                        end else begin
                            val_step = VAL_DONE;
                        end
                    end
                end

                // blank line detection on cr lf cr lf
                if (b == CH_CR) begin
                    crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
                end else if (b == CH_LF) begin
                    header_done = (crlf_seen == 2'd3);
                    crlf_seen   = (crlf_seen == 2'd1) ? 2'd2 : 2'd0;
                end else begin
                    crlf_seen = 2'd0;
                end

                // end of header decides what follows
                if (header_done) begin
                    produced = 1'b1;
                    if (!have_length) begin
                        phase  = HALTED;
                        w.kind = mhpd_pkg::KIND_NO_LEN;
                    end else if (len_acc == '0) begin
                        header_restart();
                        w.kind = mhpd_pkg::KIND_EMPTY;
                        w.last = 1'b1;
                    end else if (val_neg) begin
                        phase  = HALTED;
                        w.kind = mhpd_pkg::KIND_NEG_LEN;
                    end else begin
                        produced   = 1'b0;
                        bytes_left = len_acc;
                        phase      = IN_PAYLOAD;
                    end
                end
            end
        endcase
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_frame_word predicted;
        t_frame_word seen;
        logic        produced;
        if (!i_rst_n) begin
            header_restart();
            bytes_left = '0;
            owed_words.delete();
        end else begin
            // compare an outgoing word with the oldest owed one
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.kind = i_m_axis_tuser;
                seen.data = i_m_axis_tdata;
                seen.last = i_m_axis_tlast;
                if (owed_words.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t: unexpected word kind %0d data 0x%02h last %0b",
                                 $time, seen.kind, seen.data, seen.last);
                end else begin
                    predicted = owed_words.pop_front();
                    if (seen.kind !== predicted.kind || seen.data !== predicted.data ||
                        seen.last !== predicted.last) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= REPORT_MAX)
                            $display("%0t: word mismatch, expected kind %0d data 0x%02h",
                                     $time, predicted.kind, predicted.data,
                                     " last %0b, got kind %0d data 0x%02h last %0b",
                                     predicted.last, seen.kind, seen.data, seen.last);
                    end
                end
            end
            // predict from an accepted input word
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, produced, predicted);
                if (produced) owed_words.push_back(predicted);
            end
        end
        o_pending_count = owed_words.size();
    end

endmodule

// ===== tb/tb_mjpeg_http_part_deframer_unit.sv =====
// testbench top of the multipart deframer: clock, reset, byte stream, output stalls and verdict
module tb_mjpeg_http_part_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LENGTH_WIDTH = 31;
    localparam int         ITEM_TARGET  = 1400;
    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         IDLE_PCT     = 11;
    localparam int         TX_CALM_FROM = 400;
    localparam int         TX_CALM_TO   = 650;
    localparam int         RX_CALM_FROM = 600;
    localparam int         RX_CALM_TO   = 900;
    localparam int         RX_HOLD_LEN  = 150;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;     // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;     // [7:0] data_byte
    logic [1:0] m_axis_tuser;     // [1:0] kind
    logic       m_axis_tlast;

    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;
    int         sent_count  = 0;
    logic [7:0] stream_bytes[$];

    mjpeg_http_part_deframer_unit #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mjpeg_http_part_deframer_checker #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
    endtask

    task automatic add_eol();
        stream_bytes.push_back(CH_CR);
        stream_bytes.push_back(CH_LF);
    endtask

    task automatic add_payload(input int count);
        repeat (count) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // a header line that must not supply a length
    task automatic add_filler_line(input logic bare_lf);
        logic [7:0] c;
        case ($urandom_range(0, 8))
            0: add_text("Content-Type: image/jpeg");
            1: add_text("--boundarydonotcross");
            2: add_text("content-length: 77");
            3: add_text("Content-Length 55");
            4: add_text("Content-Lengths: 88");
            5: add_text("Content-Len: 66");
            6: add_text(" Content-Length: 44");
            7: add_text("X-Note: Content-Length: 33");
            default: begin
                // random text, no line breaks
                repeat ($urandom_range(1, 10)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                    stream_bytes.push_back(c);
                end
            end
        endcase
        if (bare_lf) stream_bytes.push_back(CH_LF);
        else add_eol();
    endtask

    // blank byte from the set skipped before the sign
    task automatic add_blanks(input int count);
        logic [7:0] blank_set[5];
        blank_set = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        repeat (count) stream_bytes.push_back(blank_set[$urandom_range(0, 4)]);
    endtask

    // the length line in one of its spellings; returns whether it ended with a bare lf
    task automatic add_length_line(input int len, output logic bare_lf);
        logic [7:0] skip_set[5];
        skip_set = '{CH_SPACE, CH_TAB, "9", "x", ":"};
        bare_lf  = ($urandom_range(0, 3) == 0);
        add_text("Content-Length:");
        if (len == 0 && $urandom_range(0, 3) == 0) begin
            // line ends while the skip is still pending
            stream_bytes.push_back(CH_LF);
            bare_lf = 1'b1;
            return;
        end
        stream_bytes.push_back(skip_set[$urandom_range(0, 4)]);
        add_blanks($urandom_range(0, 3));
        if (len == 0) begin
            case ($urandom_range(0, 3))
                0: add_text("-0");
                1: add_text("+000");
                2: add_text("0x5");
                default: add_text("none");
            endcase
        end else begin
            if ($urandom_range(0, 2) == 0) add_text("+");
            repeat ($urandom_range(0, 2)) add_text("0");
            add_text($sformatf("%0d", len));
            case ($urandom_range(0, 3))
                0: add_text(" bytes");
                1: add_text("x12");
                default: ;
            endcase
        end
        if (bare_lf) stream_bytes.push_back(CH_LF);
        else add_eol();
    endtask

    // one well-formed part: header lines, blank line, payload
    task automatic add_random_frame();
        int   len;
        logic bare_lf;
        repeat ($urandom_range(0, 2)) add_filler_line($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        add_length_line(len, bare_lf);
        // a later key line is ignored; a line after a bare lf keeps the blank line intact
        if (bare_lf || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0: add_text("Content-Length: 9999");
                1: add_text("Content-Length: -5");
                default: add_text("Content-Type: image/jpeg");
            endcase
            add_eol();
        end
        add_eol();
        add_payload(len);
    endtask

    // short directed opening
    task automatic add_directed_frames();
        // two payload bytes at both extremes
        add_text("Content-Length: 2");
        add_eol();
        add_eol();
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        // value ends before a digit: empty frame
        add_text("Content-Length:");
        add_eol();
        add_eol();
        // lf while the skip is pending: empty frame
        add_text("Content-Length:");
        stream_bytes.push_back(CH_LF);
        add_text("X: y");
        add_eol();
        add_eol();
        // minus zero: empty frame
        add_text("Content-Length: -0");
        add_eol();
        add_eol();
        // every blank, plus sign, trailing text, repeated key, line break bytes in payload
        add_text("Content-Length:9");
        stream_bytes.push_back(CH_TAB);
        stream_bytes.push_back(CH_VT);
        stream_bytes.push_back(CH_FF);
        stream_bytes.push_back(CH_CR);
        stream_bytes.push_back(CH_SPACE);
        add_text("+003 bytes");
        add_eol();
        add_text("Content-Length: 7");
        add_eol();
        add_eol();
        stream_bytes.push_back(CH_LF);
        stream_bytes.push_back(CH_CR);
        stream_bytes.push_back(8'h80);
        // other key with colons, line without colon, then the key
        add_text("Content-Type: a:b");
        add_eol();
        add_text("Content-Length 9");
        add_eol();
        add_text("Content-Length: 1");
        add_eol();
        add_eol();
        stream_bytes.push_back(8'h7F);
    endtask

    // closing part: one of the stop cases or a saturated length
    task automatic add_closing_part();
        case ($urandom_range(0, 2))
            0: begin
                // header without the key stops the block
                add_text("--b");
                add_eol();
                add_text("Content-Type: image/jpeg");
                add_eol();
                add_eol();
                add_payload(40);
            end
            1: begin
                // negative length stops the block, sometimes saturated first
                add_text("Content-Length: -");
                if ($urandom_range(0, 1) == 0) add_text("12");
                else add_text("98765432109876543210");
                add_eol();
                add_eol();
                add_payload(40);
            end
            default: begin
                // saturated length, payload never ends
                add_text("Content-Length: 123456789012345");
                add_eol();
                add_eol();
                add_payload(40);
            end
        endcase
    endtask

    // offer one word, with random idle cycles before it
    task automatic send_byte(input logic [7:0] b);
        while (!(sent_count >= TX_CALM_FROM && sent_count < TX_CALM_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        @(negedge i_clk);
    endtask

    // receiver side: random stalls, a calm stretch and two long hold-offs
    initial begin : rx_side
        int rx_cycle;
        int hold_left;
        rx_cycle      = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == 300 || rx_cycle == 1100) hold_left = RX_HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // sender side and verdict
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        add_directed_frames();
        while (stream_bytes.size() < ITEM_TARGET - 60) add_random_frame();
        add_closing_part();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (stream_bytes.size() > 0) send_byte(stream_bytes.pop_front());
        s_axis_tvalid <= 1'b0;
        // wait for every owed word, then keep watching for stray ones
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
